### hw/rtl/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg: shared definitions for the sequence recovery buffer
// Entry layout, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int SEQ_W = 32;
    localparam int TAG_W = 32;
    localparam int LEN_W = 16;
    localparam int WIN_W = 7;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_CHECK = 2'd0;
    localparam cmd_t CMD_STORE = 2'd1;
    localparam cmd_t CMD_FETCH = 2'd2;
    localparam cmd_t CMD_TICK  = 2'd3;

    typedef logic [2:0] status_t;
    localparam status_t ST_IN_ORDER     = 3'd0;
    localparam status_t ST_DUPLICATE    = 3'd1;
    localparam status_t ST_OUT_OF_ORDER = 3'd2;
    localparam status_t ST_WITHIN_WIN   = 3'd3;
    localparam status_t ST_QUEUE_READY  = 3'd4;
    localparam status_t ST_NOT_FULL     = 3'd5;
    localparam status_t ST_OVERFLOW     = 3'd6;
    localparam status_t ST_DONE         = 3'd7;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
        logic [WIN_W-1:0] life;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_SHR_RD,
        S_SHR_WR,
        S_INS_WR,
        S_SHL_RD,
        S_SHL_WR,
        S_TRIM,
        S_FIRST_CHK,
        S_FIRST_USE,
        S_TICK_RD,
        S_TICK_WR,
        S_DONE
    } state_t;

endpackage

### hw/rtl/srb_table.sv
// ----------------------------------------------------------------------------
// srb_table: entry memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srb_table #(
    parameter int DEPTH = srb_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  srb_pkg::entry_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output srb_pkg::entry_t rd_data
);
    import srb_pkg::*;

    entry_t mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/srb_ctrl.sv
// ----------------------------------------------------------------------------
// srb_ctrl: sequencer and shared compare unit
// Walks the sorted table one entry per step for search, shifts and aging.
// ----------------------------------------------------------------------------
module srb_ctrl #(
    parameter int DEPTH = srb_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic [31:0]                seq_number,
    input  logic [31:0]                payload_tag,
    input  logic [15:0]                payload_length,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 status,
    output logic                       found,
    output logic [31:0]                out_tag,
    output logic [15:0]                out_length,
    output logic [31:0]                current_seq,
    output logic [31:0]                recovered_count,
    output logic [31:0]                skipped_count,
    output logic [6:0]                 entry_count,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [6:0]                 cfg_data,
    output logic                       mem_wr_en,
    output logic [AW-1:0]              mem_wr_addr,
    output srb_pkg::entry_t            mem_wr_data,
    output logic [AW-1:0]              mem_rd_addr,
    input  srb_pkg::entry_t            mem_rd_data
);
    import srb_pkg::*;

    state_t state_reg, state_next, ret_reg, ret_next;
    cmd_t cmd_reg, cmd_next;
    logic [31:0] seq_reg, seq_next, tag_reg, tag_next, want_reg, want_next;
    logic [15:0] len_reg, len_next;
    logic [CW-1:0] held_reg, held_next, idx_reg, idx_next, dst_reg, dst_next;
    logic [CW-1:0] point_reg, point_next, visited_reg, visited_next;
    logic [31:0] cur_reg, cur_next, rec_reg, rec_next, skip_reg, skip_next;
    logic started_reg, started_next, full_reg, full_next;
    logic [6:0] ws_reg, ws_next;
    status_t st_reg, st_next;
    logic found_reg, found_next;
    logic [31:0] otag_reg, otag_next;
    logic [15:0] olen_reg, olen_next;
    logic ov_reg, ov_next;
    logic [2:0] o_st_reg, o_st_next;
    logic o_found_reg, o_found_next;
    logic [31:0] o_tag_reg, o_tag_next, o_cur_reg, o_cur_next;
    logic [31:0] o_rec_reg, o_rec_next, o_skip_reg, o_skip_next;
    logic [15:0] o_len_reg, o_len_next;
    logic [6:0] o_cnt_reg, o_cnt_next;

    logic [31:0] ws32, prev_seq;
    logic win_refuse, in_fire, out_free, at_end, hit, past, trim_go, trim_cut;
    logic [CW-1:0] front_n;
    state_t miss_state;

    assign ws32       = {25'd0, ws_reg};
    assign prev_seq   = started_reg ? cur_reg : 32'hFFFF_FFFF;
    assign in_fire    = in_valid && in_ready;
    assign out_free   = !ov_reg || out_ready;
    assign win_refuse = started_reg && (cur_reg > ws32) && (seq_number > (cur_reg - ws32))
                        && (seq_number <= cur_reg);
    assign at_end     = idx_reg >= held_reg;
    assign hit        = mem_rd_data.seq == want_reg;
    assign past       = mem_rd_data.seq > want_reg;
    assign trim_go    = 32'(held_reg) >= ws32;
    assign trim_cut   = 32'(visited_reg) > {26'd0, ws_reg[6:1]};
    assign front_n    = (point_reg < held_reg) ? point_reg : held_reg;

    // Pick where a search that does not hit goes next
    always_comb
    begin
        case (cmd_reg)
            CMD_STORE: miss_state = (32'(held_reg) >= 32'(DEPTH)) ? S_DONE : S_SHR_RD;
            CMD_FETCH: miss_state = S_TRIM;
            default:   miss_state = S_DONE;
        endcase
    end

    assign in_ready    = state_reg == S_IDLE;
    assign cfg_ready   = 1'b1;
    assign out_valid   = ov_reg;
    assign status      = o_st_reg;
    assign found       = o_found_reg;
    assign out_tag     = o_tag_reg;
    assign out_length  = o_len_reg;
    assign current_seq = o_cur_reg;
    assign recovered_count = o_rec_reg;
    assign skipped_count   = o_skip_reg;
    assign entry_count     = o_cnt_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_CHECK:
                            state_next = (ws_reg == 7'd0 || !started_reg
                                          || seq_number != cur_reg + 32'd1) ? S_DONE : S_SRCH_RD;
                        CMD_STORE: state_next = win_refuse ? S_DONE : S_SRCH_RD;
                        CMD_FETCH: state_next = (held_reg == '0) ? S_DONE : S_SRCH_RD;
                        default:   state_next = S_TICK_RD;
                    endcase
                end
            end
            S_SRCH_RD:  state_next = at_end ? miss_state : S_SRCH_CHK;
            S_SRCH_CHK:
            begin
                if (hit)
                    state_next = (cmd_reg == CMD_STORE) ? S_DONE : S_SHL_RD;
                else if (past)
                    state_next = miss_state;
                else
                    state_next = S_SRCH_RD;
            end
            S_SHR_RD:   state_next = (idx_reg == point_reg) ? S_INS_WR : S_SHR_WR;
            S_SHR_WR:   state_next = S_SHR_RD;
            S_INS_WR:   state_next = S_DONE;
            S_SHL_RD:   state_next = at_end ? ret_reg : S_SHL_WR;
            S_SHL_WR:   state_next = S_SHL_RD;
            S_TRIM:
            begin
                if (!trim_go)
                    state_next = S_DONE;
                else if (trim_cut || front_n == '0)
                    state_next = S_FIRST_CHK;
                else
                    state_next = S_SHL_RD;
            end
            S_FIRST_CHK: state_next = (held_reg != '0) ? S_FIRST_USE : S_DONE;
            S_FIRST_USE: state_next = S_SHL_RD;
            S_TICK_RD:   state_next = at_end ? S_DONE : S_TICK_WR;
            S_TICK_WR:   state_next = S_TICK_RD;
            S_DONE:      state_next = out_free ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        ret_next = ret_reg;       cmd_next = cmd_reg;       seq_next = seq_reg;
        tag_next = tag_reg;       len_next = len_reg;       want_next = want_reg;
        held_next = held_reg;     idx_next = idx_reg;       dst_next = dst_reg;
        point_next = point_reg;   visited_next = visited_reg;
        cur_next = cur_reg;       rec_next = rec_reg;       skip_next = skip_reg;
        started_next = started_reg; full_next = full_reg;
        ws_next = ws_reg;         st_next = st_reg;         found_next = found_reg;
        otag_next = otag_reg;     olen_next = olen_reg;
        ov_next = ov_reg;         o_st_next = o_st_reg;     o_found_next = o_found_reg;
        o_tag_next = o_tag_reg;   o_len_next = o_len_reg;   o_cur_next = o_cur_reg;
        o_rec_next = o_rec_reg;   o_skip_next = o_skip_reg; o_cnt_next = o_cnt_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg[AW-1:0];
        mem_wr_data = mem_rd_data;
        mem_rd_addr = idx_reg[AW-1:0];

        if (cfg_valid)
            ws_next = cfg_data;
        if (ov_reg && out_ready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next = command;   seq_next = seq_number;
                    tag_next = payload_tag; len_next = payload_length;
                    idx_next = '0;        dst_next = '0;
                    st_next = ST_DONE;    found_next = 1'b0;
                    otag_next = '0;       olen_next = '0;
                    want_next = seq_number;
                    case (command)
                        CMD_CHECK:
                        begin
                            st_next = ST_IN_ORDER;
                            if (ws_reg != 7'd0)
                            begin
                                if (!started_reg)
                                begin
                                    cur_next = seq_number;
                                    started_next = 1'b1;
                                end
                                else if (seq_number == cur_reg + 32'd1)
                                begin
                                    cur_next = seq_number;
                                    ret_next = S_DONE;
                                end
                                else if (seq_number == cur_reg)
                                    st_next = ST_DUPLICATE;
                                else
                                    st_next = ST_OUT_OF_ORDER;
                            end
                        end
                        CMD_STORE:
                        begin
                            if (win_refuse)
                                st_next = ST_WITHIN_WIN;
                            else
                                full_next = 1'b0;
                        end
                        CMD_FETCH:
                        begin
                            want_next = prev_seq + 32'd1;
                            ret_next = S_TRIM;
                        end
                        default: ;
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                // Issue the read, or close the walk at the table end
                if (at_end)
                begin
                    point_next = held_reg;
                    visited_next = held_reg;
                    idx_next = held_reg;
                    if (cmd_reg == CMD_STORE)
                        st_next = (32'(held_reg) >= 32'(DEPTH)) ? ST_OVERFLOW : st_reg;
                end
            end
            S_SRCH_CHK:
            begin
                visited_next = idx_reg + CW'(1);
                point_next = idx_reg;
                if (hit)
                begin
                    case (cmd_reg)
                        CMD_STORE:
                            st_next = (32'(held_reg) >= ws32) ? ST_QUEUE_READY : ST_NOT_FULL;
                        CMD_FETCH:
                        begin
                            if (!full_reg)
                                rec_next = rec_reg + 32'd1;
                            found_next = 1'b1;
                            otag_next = mem_rd_data.tag;
                            olen_next = mem_rd_data.len;
                            cur_next = mem_rd_data.seq;
                            started_next = 1'b1;
                        end
                        default: ;
                    endcase
                    // remove_at: copy from the next entry down
                    dst_next = idx_reg;
                    idx_next = idx_reg + CW'(1);
                end
                else if (past)
                begin
                    if (cmd_reg == CMD_STORE && 32'(held_reg) >= 32'(DEPTH))
                        st_next = ST_OVERFLOW;
                    idx_next = held_reg;
                end
                else
                    idx_next = idx_reg + CW'(1);
            end
            S_SHR_RD:
            begin
                mem_rd_addr = AW'(idx_reg - CW'(1));
            end
            S_SHR_WR:
            begin
                mem_wr_en = 1'b1;
                mem_wr_addr = idx_reg[AW-1:0];
                idx_next = idx_reg - CW'(1);
            end
            S_INS_WR:
            begin
                mem_wr_en = 1'b1;
                mem_wr_addr = point_reg[AW-1:0];
                mem_wr_data.seq = seq_reg;
                mem_wr_data.tag = tag_reg;
                mem_wr_data.len = len_reg;
                mem_wr_data.life = ws_reg;
                held_next = held_reg + CW'(1);
                st_next = (32'(held_reg) + 32'd1 >= ws32) ? ST_QUEUE_READY : ST_NOT_FULL;
            end
            S_SHL_RD:
            begin
                // Table shrinks to where the copy stopped
                if (at_end)
                    held_next = dst_reg;
            end
            S_SHL_WR:
            begin
                mem_wr_en = 1'b1;
                mem_wr_addr = dst_reg[AW-1:0];
                idx_next = idx_reg + CW'(1);
                dst_next = dst_reg + CW'(1);
            end
            S_TRIM:
            begin
                if (trim_go)
                begin
                    full_next = 1'b1;
                    if (trim_cut)
                    begin
                        if (point_reg < held_reg)
                            held_next = point_reg;
                    end
                    else
                    begin
                        idx_next = front_n;
                        dst_next = '0;
                        ret_next = S_FIRST_CHK;
                    end
                end
            end
            S_FIRST_CHK:
            begin
                mem_rd_addr = '0;
            end
            S_FIRST_USE:
            begin
                found_next = 1'b1;
                otag_next = mem_rd_data.tag;
                olen_next = mem_rd_data.len;
                skip_next = skip_reg + mem_rd_data.seq - prev_seq - 32'd1;
                cur_next = mem_rd_data.seq;
                started_next = 1'b1;
                idx_next = CW'(1);
                dst_next = '0;
                ret_next = S_DONE;
            end
            S_TICK_RD:
            begin
                if (at_end)
                    held_next = dst_reg;
            end
            S_TICK_WR:
            begin
                // Keep live entries with one less lifetime, drop expired ones
                idx_next = idx_reg + CW'(1);
                if (mem_rd_data.life > 7'd1)
                begin
                    mem_wr_en = 1'b1;
                    mem_wr_addr = dst_reg[AW-1:0];
                    mem_wr_data.life = mem_rd_data.life - 7'd1;
                    dst_next = dst_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    o_st_next = st_reg;
                    o_found_next = found_reg;
                    o_tag_next = otag_reg;
                    o_len_next = olen_reg;
                    o_cur_next = cur_reg;
                    o_rec_next = rec_reg;
                    o_skip_next = skip_reg;
                    o_cnt_next = 7'(held_reg);
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg <= '0;
            cur_reg <= '0;
            started_reg <= 1'b0;
            full_reg <= 1'b0;
            rec_reg <= '0;
            skip_reg <= '0;
            ws_reg <= 7'd16;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg <= held_next;
            cur_reg <= cur_next;
            started_reg <= started_next;
            full_reg <= full_next;
            rec_reg <= rec_next;
            skip_reg <= skip_next;
            ws_reg <= ws_next;
            ov_reg <= ov_next;
        end
    end

    // Payload and work registers
    always_ff @(posedge clk)
    begin
        ret_reg <= ret_next;     cmd_reg <= cmd_next;     seq_reg <= seq_next;
        tag_reg <= tag_next;     len_reg <= len_next;     want_reg <= want_next;
        idx_reg <= idx_next;     dst_reg <= dst_next;     point_reg <= point_next;
        visited_reg <= visited_next;
        st_reg <= st_next;       found_reg <= found_next;
        otag_reg <= otag_next;   olen_reg <= olen_next;
        o_st_reg <= o_st_next;   o_found_reg <= o_found_next;
        o_tag_reg <= o_tag_next; o_len_reg <= o_len_next; o_cur_reg <= o_cur_next;
        o_rec_reg <= o_rec_next; o_skip_reg <= o_skip_next; o_cnt_reg <= o_cnt_next;
    end

endmodule

### hw/rtl/sequence_recovery_buffer_unit.sv
// ----------------------------------------------------------------------------
// sequence_recovery_buffer_unit: packet resequencing buffer
// Classifies sequence numbers, stores out-of-order packet handles in a
// sorted table, hands them out in order, trims and ages the table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command with its number,
//   tag and length. Output channel (out_valid/out_ready) returns one result
//   per command with status, fetched entry and running counters.
//   Config channel (cfg_valid/cfg_ready) writes window_size; write it only
//   while the block is idle. It is always ready.
//   Each command walks the sorted table one entry at a time through a
//   single read port for a search, a shift, or an aging pass, and a fetch
//   that trims may do a search plus up to three shifts. A command is
//   accepted, walks the table, and then loads the result register.
//   in_ready is high only between commands.
//   A finished result sits in the output register; the next command is
//   taken while it waits, and its own result holds until that slot frees.
//   Reset empties the table, clears counters and sets window_size to 16.
// ----------------------------------------------------------------------------
module sequence_recovery_buffer_unit #(
    parameter int TABLE_DEPTH = srb_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] seq_number,
    input  logic [31:0] payload_tag,
    input  logic [15:0] payload_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        found,
    output logic [31:0] out_tag,
    output logic [15:0] out_length,
    output logic [31:0] current_seq,
    output logic [31:0] recovered_count,
    output logic [31:0] skipped_count,
    output logic [6:0]  entry_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    import srb_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_data;

    // Sequencer
    srb_ctrl #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .seq_number(seq_number),
        .payload_tag(payload_tag), .payload_length(payload_length),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .found(found), .out_tag(out_tag), .out_length(out_length),
        .current_seq(current_seq), .recovered_count(recovered_count),
        .skipped_count(skipped_count), .entry_count(entry_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .mem_wr_en(wr_en), .mem_wr_addr(wr_addr), .mem_wr_data(wr_data),
        .mem_rd_addr(rd_addr), .mem_rd_data(rd_data)
    );

    // Entry store
    srb_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

endmodule
